// ===== hw/rtl/dlt_pkg.sv =====
package dlt_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int ADDR_W      = 64;
    localparam int VALUE_W     = 64;
    localparam int SIZE_W      = 4;
    localparam int STAMP_W     = 64;
    localparam int VER_W       = 32;
    localparam int SLOT_W      = 4;
    localparam int FILL_W      = 5;
    localparam int ACTION_W    = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_DUP     = 2'd0,
        ACT_INSERT  = 2'd1,
        ACT_REPLACE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_COMMIT
    } ctl_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  site_address;
        logic [VALUE_W-1:0] operand_value;
        logic [SIZE_W-1:0]  operand_bytes;
    } key_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic commit;
    } dlt_cmd_t;

    typedef struct packed {
        logic table_empty;
        logic out_busy;
    } dlt_status_t;

endpackage

// ===== hw/rtl/dlt_if.sv =====
interface dlt_in_if;
    import dlt_pkg::*;

    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  site_address;
    logic [VALUE_W-1:0] operand_value;
    logic [SIZE_W-1:0]  operand_bytes;

    modport source (output valid, output site_address, output operand_value,
                    output operand_bytes, input ready);
    modport sink (input valid, input site_address, input operand_value,
                  input operand_bytes, output ready);
endinterface

interface dlt_out_if;
    import dlt_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot;
    logic [FILL_W-1:0]   fill_count;
    logic [VER_W-1:0]    content_version;

    modport source (output valid, output action, output slot, output fill_count,
                    output content_version, input ready);
    modport sink (input valid, input action, input slot, input fill_count,
                  input content_version, output ready);
endinterface

// ===== hw/rtl/dlt_ctrl.sv =====
module dlt_ctrl
    import dlt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int IDX_W   = $clog2(ENTRIES),
    parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  dlt_status_t      status,
    input  logic [CNT_W-1:0] fill,
    output dlt_cmd_t         cmd,
    output logic [IDX_W-1:0] rd_addr
);

    ctl_state_t       state_reg;
    ctl_state_t       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        rd_addr    = cnt_reg[IDX_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = status.table_empty ? ST_COMMIT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (cnt_reg + CNT_W'(1) == fill)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/dlt_datapath.sv =====
module dlt_datapath
    import dlt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int IDX_W   = $clog2(ENTRIES),
    parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  key_t                item_key,
    input  dlt_cmd_t            cmd,
    input  logic [IDX_W-1:0]    rd_addr,
    output dlt_status_t         status,
    output logic [CNT_W-1:0]    fill,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [ACTION_W-1:0] out_action,
    output logic [SLOT_W-1:0]   out_slot,
    output logic [FILL_W-1:0]   out_fill_count,
    output logic [VER_W-1:0]    out_content_version
);

    key_t               key_mem [ENTRIES];
    logic [STAMP_W-1:0] stamp_mem [ENTRIES];

    key_t               key_reg;
    key_t               rd_key_reg;
    logic [STAMP_W-1:0] rd_stamp_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               rd_valid_reg;

    logic [STAMP_W-1:0] stamp_clock_reg;
    logic [CNT_W-1:0]   valid_entries_reg;
    logic [VER_W-1:0]   version_reg;

    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [STAMP_W-1:0] min_stamp_reg;
    logic [IDX_W-1:0]   min_idx_reg;

    logic                out_valid_reg;
    logic [ACTION_W-1:0] out_action_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [FILL_W-1:0]   out_fill_reg;

    logic               full;
    logic               match;
    logic               take_min;
    logic [IDX_W-1:0]   wr_idx;
    action_t            act;
    logic [CNT_W-1:0]   valid_entries_next;
    logic [VER_W-1:0]   version_next;

    assign full     = valid_entries_reg == CNT_W'(ENTRIES);
    assign match    = rd_key_reg == key_reg;
    assign take_min = (rd_idx_reg == '0) || (rd_stamp_reg < min_stamp_reg);

    always_comb
    begin
        valid_entries_next = valid_entries_reg;
        version_next       = version_reg + VER_W'(1);
        priority if (hit_reg)
        begin
            act          = ACT_DUP;
            wr_idx       = hit_idx_reg;
            version_next = version_reg;
        end
        else if (!full)
        begin
            act                = ACT_INSERT;
            wr_idx             = IDX_W'(valid_entries_reg);
            valid_entries_next = valid_entries_reg + CNT_W'(1);
        end
        else
        begin
            act    = ACT_REPLACE;
            wr_idx = min_idx_reg;
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            stamp_mem[wr_idx] <= stamp_clock_reg;
            if (!hit_reg)
            begin
                key_mem[wr_idx] <= key_reg;
            end
        end
        if (cmd.rd_en)
        begin
            rd_key_reg   <= key_mem[rd_addr];
            rd_stamp_reg <= stamp_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= item_key;
        end
        if (cmd.rd_en)
        begin
            rd_idx_reg <= rd_addr;
        end
        if (rd_valid_reg && !hit_reg && match)
        begin
            hit_idx_reg <= rd_idx_reg;
        end
        if (rd_valid_reg && take_min)
        begin
            min_stamp_reg <= rd_stamp_reg;
            min_idx_reg   <= rd_idx_reg;
        end
        if (cmd.commit)
        begin
            out_action_reg <= act;
            out_slot_reg   <= SLOT_W'(wr_idx);
            out_fill_reg   <= FILL_W'(valid_entries_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_clock_reg   <= '0;
            valid_entries_reg <= '0;
            version_reg       <= '0;
            rd_valid_reg      <= 1'b0;
            hit_reg           <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en;
            if (cmd.load)
            begin
                stamp_clock_reg <= stamp_clock_reg + STAMP_W'(1);
                hit_reg         <= 1'b0;
            end
            else if (rd_valid_reg && match)
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                valid_entries_reg <= valid_entries_next;
                version_reg       <= version_next;
                out_valid_reg     <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign fill                = valid_entries_reg;
    assign status.table_empty  = valid_entries_reg == '0;
    assign status.out_busy     = out_valid_reg && !out_ready;
    assign out_valid           = out_valid_reg;
    assign out_action          = out_action_reg;
    assign out_slot            = out_slot_reg;
    assign out_fill_count      = out_fill_reg;
    assign out_content_version = version_reg;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_entries_reg <= CNT_W'(ENTRIES))
        else $error("fill count beyond table size");

    a_dup_keeps_version: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && hit_reg |=> $stable(version_reg) && $stable(valid_entries_reg))
        else $error("duplicate changed table content state");

    a_change_bumps_version: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && !hit_reg |=> version_reg == $past(version_reg) + VER_W'(1))
        else $error("insert or replace without version step");

    a_commit_free_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !out_valid_reg || out_ready)
        else $error("result overwritten before transfer");

    a_replace_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && !hit_reg && !full |=> valid_entries_reg == $past(valid_entries_reg) + CNT_W'(1))
        else $error("insert without fill step");
`endif

endmodule

// ===== hw/rtl/dedup_lru_tuple_table.sv =====
// the input transfer loads the key; the scan then reads one entry per cycle and compares
// each with the key; a flush state takes the last compare and the commit state writes back;
// with an empty table the scan is skipped and the item goes straight to commit
// a new transfer is taken only in the idle state, after the previous item has committed;
// a result not yet taken holds back the write-back of the following item
// reset: fill count, stamp clock and content version clear at once; entry memory is not cleared
module dedup_lru_tuple_table
    import dlt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input logic        clk,
    input logic        rst_n,
    dlt_in_if.sink     item_in,
    dlt_out_if.source  result_out
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    dlt_cmd_t         cmd;
    dlt_status_t      status;
    logic [CNT_W-1:0] fill;
    logic [IDX_W-1:0] rd_addr;
    logic             in_ready;
    key_t             item_key;

    assign item_key.site_address  = item_in.site_address;
    assign item_key.operand_value = item_in.operand_value;
    assign item_key.operand_bytes = item_in.operand_bytes;
    assign item_in.ready          = in_ready;

    dlt_ctrl #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_in.valid),
        .in_ready (in_ready),
        .status   (status),
        .fill     (fill),
        .cmd      (cmd),
        .rd_addr  (rd_addr)
    );

    dlt_datapath #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .item_key            (item_key),
        .cmd                 (cmd),
        .rd_addr             (rd_addr),
        .status              (status),
        .fill                (fill),
        .out_ready           (result_out.ready),
        .out_valid           (result_out.valid),
        .out_action          (result_out.action),
        .out_slot            (result_out.slot),
        .out_fill_count      (result_out.fill_count),
        .out_content_version (result_out.content_version)
    );

endmodule
